// ===== sv/pli_pkg.sv =====
package pli_pkg;

  // Field widths fixed by the item format.
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 6;
  localparam int CFG_W   = 7;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int QSAT_W  = 35;
  localparam int SUM_W   = 37;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Reset value of the breakpoint count register.
  localparam logic [CFG_W-1:0] POINTS_RESET = 7'd2;

  // Quotient saturation limit (2^34).
  localparam logic [PROD_W-1:0] QUO_LIMIT = 64'h0000_0004_0000_0000;

  // Saturation bounds of the signed 32-bit result.
  localparam logic signed [SUM_W-1:0] RES_MAX = 37'sh0_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] RES_MIN = -37'sh0_8000_0000;

  // One table entry as stored in the breakpoint memory.
  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } bp_entry_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANGE,
    ST_SEG0,
    ST_SEG1,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } pli_state_t;

endpackage

// ===== sv/pli_ifs.sv =====
// Input channel: load or query items.
interface pli_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [pli_pkg::IDX_W-1:0]            entry_index;
  logic signed [pli_pkg::VAL_W-1:0]     point_x;
  logic signed [pli_pkg::VAL_W-1:0]     point_y;
  logic signed [pli_pkg::VAL_W-1:0]     query_x;

  modport source (output valid, kind, entry_index, point_x, point_y, query_x,
                  input ready);
  modport sink (input valid, kind, entry_index, point_x, point_y, query_x,
                output ready);
endinterface

// Result channel: interpolated values.
interface pli_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pli_pkg::VAL_W-1:0]     result_y;
  logic                                 out_of_range;

  modport source (output valid, result_y, out_of_range, input ready);
  modport sink (input valid, result_y, out_of_range, output ready);
endinterface

// ===== sv/pli_bp_mem.sv =====
module pli_bp_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  pli_pkg::bp_entry_t  wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output pli_pkg::bp_entry_t  rd_data
);

  pli_pkg::bp_entry_t mem_r [DEPTH];
  pli_pkg::bp_entry_t rd_data_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/pli_div.sv =====
module pli_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pli_pkg::PROD_W-1:0]     dividend,
  input  logic [pli_pkg::VAL_W-1:0]      divisor,
  output logic                           done,
  output logic [pli_pkg::PROD_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(pli_pkg::PROD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pli_pkg::PROD_W - 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [pli_pkg::VAL_W:0]       rem_r, rem_nxt;
  logic [pli_pkg::PROD_W-1:0]    quo_r, quo_nxt;
  logic [pli_pkg::VAL_W-1:0]     div_r, div_nxt;
  logic [pli_pkg::VAL_W:0]       rem_shift;
  logic [pli_pkg::VAL_W:0]       div_ext;

  // One restoring step per cycle; the dividend shifts out of the quotient
  // register as quotient bits shift in.
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    rem_shift = {rem_r[pli_pkg::VAL_W-1:0], quo_r[pli_pkg::PROD_W-1]};
    div_ext   = {1'b0, div_r};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_shift >= div_ext) begin
        rem_nxt = rem_shift - div_ext;
        quo_nxt = {quo_r[pli_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift;
        quo_nxt = {quo_r[pli_pkg::PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/piecewise_linear_interpolator.sv =====
// Load items give no result and leave the block ready; the next item is taken next cycle.
// Query items scan the n breakpoints in use through the single memory read port,
// where n is the breakpoint count in use, and check the range; an out-of-range query
// then finishes, otherwise the segment is read, multiplied and divided by a restoring divider.
// One item is worked on at a time; a finished result waits in an output register.
// Synchronous active-low reset clears control state and sets the count to 2.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pli_in_if.sink                     in_ch,
  pli_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [pli_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  pli_pkg::pli_state_t               state_r, state_nxt;
  logic [pli_pkg::CFG_W-1:0]         points_in_use_r;
  logic signed [pli_pkg::VAL_W-1:0]  q_r, q_nxt;
  logic [CW-1:0]                     n_r, n_nxt;
  logic [CW-1:0]                     chk_r, chk_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [CW-1:0]                     seg_r, seg_nxt;
  logic signed [pli_pkg::VAL_W-1:0]  xfirst_r, xfirst_nxt;
  logic signed [pli_pkg::VAL_W-1:0]  xlast_r, xlast_nxt;
  logic signed [pli_pkg::VAL_W-1:0]  x0_r, x0_nxt;
  logic signed [pli_pkg::VAL_W-1:0]  y0_r, y0_nxt;
  logic [pli_pkg::VAL_W-1:0]         step_r, step_nxt;
  logic [pli_pkg::VAL_W-1:0]         mag_a_r, mag_a_nxt;
  logic [pli_pkg::VAL_W-1:0]         mag_b_r, mag_b_nxt;
  logic                              neg_r, neg_nxt;
  logic                              oor_r, oor_nxt;
  logic [pli_pkg::PROD_W-1:0]        prod_r, prod_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [pli_pkg::VAL_W-1:0]  out_y_r, out_y_nxt;
  logic                              out_oor_r, out_oor_nxt;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  pli_pkg::bp_entry_t                mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  pli_pkg::bp_entry_t                mem_rdata;
  logic                              div_start;
  logic                              div_done;
  logic [pli_pkg::PROD_W-1:0]        div_quo;

  logic                              in_xfer;
  logic                              out_free;
  logic [31:0]                       ent_ext;
  logic [31:0]                       pts_ext;
  logic [31:0]                       n_full;
  logic [CW-1:0]                     scan_addr;
  logic [CW-1:0]                     seg_prev;
  logic [CW-1:0]                     seg_idx;
  logic signed [pli_pkg::VAL_W:0]    step_w;
  logic signed [pli_pkg::VAL_W:0]    dxq_w;
  logic signed [pli_pkg::VAL_W:0]    dy_w;
  logic [pli_pkg::VAL_W:0]           dxq_abs;
  logic [pli_pkg::VAL_W:0]           dy_abs;
  logic [pli_pkg::QSAT_W-1:0]        quo_sat;
  logic signed [pli_pkg::SUM_W-1:0]  sum_w;
  logic signed [pli_pkg::VAL_W-1:0]  res_y;

  pli_bp_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  pli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (step_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ch.ready     = (state_r == pli_pkg::ST_IDLE);
  assign in_xfer         = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.result_y = out_y_r;
  assign out_ch.out_of_range = out_oor_r;
  assign out_free        = !out_valid_r || out_ch.ready;

  // Effective point count, saturated to 2..MAX_POINTS.
  always_comb begin
    pts_ext = 32'(points_in_use_r);
    if (pts_ext < 32'd2) begin
      n_full = 32'd2;
    end else if (pts_ext > 32'(MAX_POINTS)) begin
      n_full = 32'(MAX_POINTS);
    end else begin
      n_full = pts_ext;
    end
  end

  // Segment index clamped to 1..n-1.
  always_comb begin
    if (cnt_r == '0) begin
      seg_idx = CW'(1);
    end else if (cnt_r == n_r) begin
      seg_idx = n_r - CW'(1);
    end else begin
      seg_idx = cnt_r;
    end
    seg_prev  = seg_idx - CW'(1);
    scan_addr = chk_r + CW'(1);
    ent_ext   = 32'(in_ch.entry_index);
  end

  // Segment differences from the second breakpoint read.
  always_comb begin
    step_w  = {mem_rdata.x[pli_pkg::VAL_W-1], mem_rdata.x} -
              {x0_r[pli_pkg::VAL_W-1], x0_r};
    dxq_w   = {q_r[pli_pkg::VAL_W-1], q_r} - {x0_r[pli_pkg::VAL_W-1], x0_r};
    dy_w    = {mem_rdata.y[pli_pkg::VAL_W-1], mem_rdata.y} -
              {y0_r[pli_pkg::VAL_W-1], y0_r};
    dxq_abs = dxq_w[pli_pkg::VAL_W] ? 33'(-dxq_w) : 33'(dxq_w);
    dy_abs  = dy_w[pli_pkg::VAL_W] ? 33'(-dy_w) : 33'(dy_w);
  end

  // Final value: saturate the quotient, add it to or subtract it from y0 by sign, saturate the sum.
  always_comb begin
    if (div_quo > pli_pkg::QUO_LIMIT) begin
      quo_sat = pli_pkg::QUO_LIMIT[pli_pkg::QSAT_W-1:0];
    end else begin
      quo_sat = div_quo[pli_pkg::QSAT_W-1:0];
    end
    if (neg_r) begin
      sum_w = 37'(y0_r) - $signed({2'b00, quo_sat});
    end else begin
      sum_w = 37'(y0_r) + $signed({2'b00, quo_sat});
    end
    if (sum_w > pli_pkg::RES_MAX) begin
      res_y = pli_pkg::RES_MAX[pli_pkg::VAL_W-1:0];
    end else if (sum_w < pli_pkg::RES_MIN) begin
      res_y = pli_pkg::RES_MIN[pli_pkg::VAL_W-1:0];
    end else begin
      res_y = sum_w[pli_pkg::VAL_W-1:0];
    end
  end

  // Controller: next state, memory accesses and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    n_nxt         = n_r;
    chk_nxt       = chk_r;
    cnt_nxt       = cnt_r;
    seg_nxt       = seg_r;
    xfirst_nxt    = xfirst_r;
    xlast_nxt     = xlast_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    step_nxt      = step_r;
    mag_a_nxt     = mag_a_r;
    mag_b_nxt     = mag_b_r;
    neg_nxt       = neg_r;
    oor_nxt       = oor_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_y_nxt     = out_y_r;
    out_oor_nxt   = out_oor_r;
    mem_we        = 1'b0;
    mem_waddr     = ent_ext[AW-1:0];
    mem_wdata     = '{x: in_ch.point_x, y: in_ch.point_y};
    mem_re        = 1'b0;
    mem_raddr     = '0;
    div_start     = 1'b0;

    unique case (state_r)
      pli_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.kind == pli_pkg::KIND_LOAD) begin
            mem_we = (ent_ext < 32'(MAX_POINTS));
          end else begin
            // Start the scan with entry 0.
            q_nxt     = in_ch.query_x;
            n_nxt     = CW'(n_full);
            chk_nxt   = '0;
            cnt_nxt   = '0;
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_nxt = pli_pkg::ST_SCAN;
          end
        end
      end
      pli_pkg::ST_SCAN: begin
        // Count entries below the query; keep the first and last abscissa.
        if (mem_rdata.x < q_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (chk_r == '0) begin
          xfirst_nxt = mem_rdata.x;
        end
        mem_re    = 1'b1;
        mem_raddr = scan_addr[AW-1:0];
        chk_nxt   = scan_addr;
        if (chk_r == n_r - CW'(1)) begin
          xlast_nxt = mem_rdata.x;
          mem_re    = 1'b0;
          state_nxt = pli_pkg::ST_RANGE;
        end
      end
      pli_pkg::ST_RANGE: begin
        if (q_r < xfirst_r || q_r > xlast_r) begin
          oor_nxt   = 1'b1;
          state_nxt = pli_pkg::ST_DONE;
        end else begin
          oor_nxt   = 1'b0;
          seg_nxt   = seg_idx;
          mem_re    = 1'b1;
          mem_raddr = seg_prev[AW-1:0];
          state_nxt = pli_pkg::ST_SEG0;
        end
      end
      pli_pkg::ST_SEG0: begin
        x0_nxt    = mem_rdata.x;
        y0_nxt    = mem_rdata.y;
        mem_re    = 1'b1;
        mem_raddr = seg_r[AW-1:0];
        state_nxt = pli_pkg::ST_SEG1;
      end
      pli_pkg::ST_SEG1: begin
        // A non-positive step counts as one LSB.
        if (step_w[pli_pkg::VAL_W] || step_w == '0) begin
          step_nxt = 32'd1;
        end else begin
          step_nxt = step_w[pli_pkg::VAL_W-1:0];
        end
        mag_a_nxt = dxq_abs[pli_pkg::VAL_W-1:0];
        mag_b_nxt = dy_abs[pli_pkg::VAL_W-1:0];
        neg_nxt   = dxq_w[pli_pkg::VAL_W] != dy_w[pli_pkg::VAL_W];
        state_nxt = pli_pkg::ST_MUL;
      end
      pli_pkg::ST_MUL: begin
        prod_nxt  = 64'(mag_a_r) * 64'(mag_b_r);
        state_nxt = pli_pkg::ST_DIV_START;
      end
      pli_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = pli_pkg::ST_DIV_WAIT;
      end
      pli_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = pli_pkg::ST_DONE;
        end
      end
      pli_pkg::ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_oor_nxt   = oor_r;
          out_y_nxt     = oor_r ? '0 : res_y;
          state_nxt     = pli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pli_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= pli_pkg::ST_IDLE;
      out_valid_r     <= 1'b0;
      points_in_use_r <= pli_pkg::POINTS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        points_in_use_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    n_r       <= n_nxt;
    chk_r     <= chk_nxt;
    cnt_r     <= cnt_nxt;
    seg_r     <= seg_nxt;
    xfirst_r  <= xfirst_nxt;
    xlast_r   <= xlast_nxt;
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    step_r    <= step_nxt;
    mag_a_r   <= mag_a_nxt;
    mag_b_r   <= mag_b_nxt;
    neg_r     <= neg_nxt;
    oor_r     <= oor_nxt;
    prod_r    <= prod_nxt;
    out_y_r   <= out_y_nxt;
    out_oor_r <= out_oor_nxt;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int TABLE_DEPTH  = 64;
  localparam int ITEM_TARGET  = 1100;
  localparam int LOAD_SETTLE  = 8;
  localparam int DRAIN_CYCLES = 150;
  localparam int IDLE_LIMIT   = 3000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic                             kind;
    logic [pli_pkg::IDX_W-1:0]        entry_index;
    logic signed [pli_pkg::VAL_W-1:0] point_x;
    logic signed [pli_pkg::VAL_W-1:0] point_y;
    logic signed [pli_pkg::VAL_W-1:0] query_x;
  } pli_item_t;

  typedef struct packed {
    logic signed [pli_pkg::VAL_W-1:0] y;
    logic                             oor;
  } interp_t;

  // One directed row: an optional count write, the item, and an optional typed answer.
  typedef struct packed {
    logic                             do_cfg;
    logic [pli_pkg::CFG_W-1:0]        cfg_val;
    pli_item_t                        item;
    logic                             chk;
    logic signed [pli_pkg::VAL_W-1:0] exp_y;
    logic                             exp_oor;
  } stim_row_t;

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // Unit segment from (0, 0) to (1.0, 2.0) with the reset count of two.
    '{1'b0, 7'd0, '{pli_pkg::KIND_LOAD,  6'd0, 32'h0000_0000, 32'h0000_0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_LOAD,  6'd1, 32'h0001_0000, 32'h0002_0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0000_0000},
      1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000},
      1'b1, 32'h0001_0000, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0001_0000},
      1'b1, 32'h0002_0000, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_FFFF},
      1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0001_0001},
      1'b1, 32'h0000_0000, 1'b1},
    // Segment spanning the whole signed range with extreme ordinates.
    '{1'b0, 7'd0, '{pli_pkg::KIND_LOAD,  6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_LOAD,  6'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h8000_0000},
      1'b1, 32'h7FFF_FFFF, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h7FFF_FFFF},
      1'b1, 32'h8000_0000, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0000_0000},
      1'b0, 32'h0, 1'b0},
    // Four unsorted points: a falling x step and an overflowing sum.
    '{1'b1, 7'd4, '{pli_pkg::KIND_LOAD,  6'd0, 32'h0000_0000, 32'h0000_0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_LOAD,  6'd1, 32'h0003_0000, 32'h0001_0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_LOAD,  6'd2, 32'h0001_0000, 32'h7FFF_0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_LOAD,  6'd3, 32'h0004_0000, 32'h8000_0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0002_0000},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0004_0000},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0004_0001},
      1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_0000},
      1'b1, 32'h0000_0000, 1'b1},
    // A count of zero saturates up to two points.
    '{1'b1, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0002_0000},
      1'b0, 32'h0, 1'b0},
    // Two equal abscissas give a zero step.
    '{1'b1, 7'd2, '{pli_pkg::KIND_LOAD,  6'd1, 32'h0000_0000, 32'h0001_0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{1'b0, 7'd0, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0000_0000},
      1'b1, 32'h0000_0000, 1'b0},
    '{1'b1, 7'd1, '{pli_pkg::KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0000_0000},
      1'b1, 32'h0000_0000, 1'b0}
  };

  localparam logic [pli_pkg::CFG_W-1:0] PHASE_POINTS [8] = '{
    7'd64, 7'd1, 7'd127, 7'd3, 7'd65, 7'd2, 7'd8, 7'd0
  };

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [pli_pkg::CFG_W-1:0]    cfg_wdata;

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  piecewise_linear_interpolator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the breakpoint table and count register.
  logic signed [pli_pkg::VAL_W-1:0] knot_x [TABLE_DEPTH];
  logic signed [pli_pkg::VAL_W-1:0] knot_y [TABLE_DEPTH];
  logic [pli_pkg::CFG_W-1:0]        points_cfg;

  interp_t pending_values [$];

  int mismatches    = 0;
  int items_done    = 0;
  int queries_done  = 0;
  int oor_expected  = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;
  int sink_mode     = 0;
  int sink_cycle    = 0;
  int hold_left     = 0;
  logic hold_level  = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Breakpoint count after saturation to the usable range.
  function automatic int points_active();
    if (points_cfg < 2) return 2;
    if (points_cfg > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(points_cfg);
  endfunction

  // Interpolated value at q over the shadow table.
  function automatic interp_t interpolate_at(logic signed [pli_pkg::VAL_W-1:0] q);
    int n;
    int below;
    int seg;
    longint x0, x1, y0, y1, step, dxq, dy, a_abs, b_abs, val;
    logic [127:0] quo;
    logic neg;
    interp_t r;
    n = points_active();
    if (q < knot_x[0] || q > knot_x[n-1]) begin
      r.y = '0;
      r.oor = 1'b1;
      return r;
    end
    below = 0;
    for (int k = 0; k < n; k++) begin
      if (knot_x[k] < q) below++;
    end
    seg = (below < 1) ? 1 : ((below > n - 1) ? n - 1 : below);
    x0 = longint'(knot_x[seg-1]);
    x1 = longint'(knot_x[seg]);
    y0 = longint'(knot_y[seg-1]);
    y1 = longint'(knot_y[seg]);
    step = x1 - x0;
    if (step <= 0) step = 1;
    dxq = longint'(q) - x0;
    dy = y1 - y0;
    neg = (dxq < 0) != (dy < 0);
    a_abs = (dxq < 0) ? -dxq : dxq;
    b_abs = (dy < 0) ? -dy : dy;
    // Exact wide product, quotient truncated toward zero on the magnitudes.
    quo = (128'(a_abs) * 128'(b_abs)) / 128'(step);
    if (quo > pli_pkg::QUO_LIMIT) quo = pli_pkg::QUO_LIMIT;
    val = neg ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    r.y = val[pli_pkg::VAL_W-1:0];
    r.oor = 1'b0;
    return r;
  endfunction

  function automatic void flag_mismatch(string what, logic [pli_pkg::VAL_W-1:0] want,
                                        logic [pli_pkg::VAL_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // Drive one item and hold it until the transfer; idle between bursts.
  task automatic send_item(input pli_item_t it, input logic typed, input interp_t typed_val);
    int gap;
    int pick;
    interp_t want_val;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) gap = 0;
      else if (pick < 8) gap = $urandom_range(1, 4);
      else if (pick < 9) gap = $urandom_range(5, 12);
      else gap = $urandom_range(20, 25);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= it.kind;
    in_ch.entry_index <= it.entry_index;
    in_ch.point_x     <= it.point_x;
    in_ch.point_y     <= it.point_y;
    in_ch.query_x     <= it.query_x;
    do @(posedge clk); while (!in_ch.ready);
    items_done++;
    // Update the shadow state in transfer order.
    if (it.kind == pli_pkg::KIND_LOAD) begin
      knot_x[it.entry_index] = it.point_x;
      knot_y[it.entry_index] = it.point_y;
    end else begin
      queries_done++;
      want_val = typed ? typed_val : interpolate_at(it.query_x);
      pending_values = {pending_values, want_val};
      if (want_val.oor) oor_expected++;
    end
  endtask

  // Write the count register once the block has gone quiet.
  task automatic write_points(input logic [pli_pkg::CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    points_cfg = value;
    cfg_writes++;
  endtask

  // Fill entries 0..n-1: mostly ascending abscissas, sometimes scrambled.
  task automatic load_table(input int n);
    int mode;
    int ymode;
    longint maxstep, room, x, y, u;
    pli_item_t it;
    interp_t none;
    none = '0;
    mode = $urandom_range(0, 9);
    ymode = $urandom_range(0, 2);
    unique case (mode % 4)
      0: maxstep = 3;
      1: maxstep = 'h100;
      2: maxstep = 'h4_0000;
      default: maxstep = 64'hFFFF_FFFF / (n - 1);
    endcase
    room = 64'h1_0000_0000 - maxstep * (n - 1);
    u = $urandom;
    x = -64'sd2147483648 + (u % room);
    y = 0;
    for (int k = 0; k < n; k++) begin
      if (k > 0) x = x + $urandom_range(0, maxstep);
      if (ymode == 0) y = longint'(int'($urandom));
      else if (ymode == 1) y = longint'($urandom_range(0, 'h8_0000)) - 'h4_0000;
      else y = y + longint'($urandom_range(0, 'h2_0000)) - 'h1_0000;
      it.kind        = pli_pkg::KIND_LOAD;
      it.entry_index = k[pli_pkg::IDX_W-1:0];
      it.point_x     = (mode >= 8) ? $urandom : x[pli_pkg::VAL_W-1:0];
      it.point_y     = y[pli_pkg::VAL_W-1:0];
      it.query_x     = $urandom;
      send_item(it, 1'b0, none);
    end
  endtask

  // Query abscissa: mostly inside the table, with knots, edges and wild values.
  function automatic logic signed [pli_pkg::VAL_W-1:0] pick_query(int n);
    longint lo_x, hi_x, q, u;
    int sel;
    lo_x = longint'(knot_x[0]);
    hi_x = longint'(knot_x[n-1]);
    sel = $urandom_range(0, 99);
    u = $urandom;
    if (sel < 15 || hi_x < lo_x) q = longint'(int'($urandom));
    else if (sel < 30) q = longint'(knot_x[$urandom_range(0, n - 1)]);
    else if (sel < 40) q = $urandom_range(0, 1) ? lo_x - 1 : hi_x + 1;
    else q = lo_x + (u % (hi_x - lo_x + 1));
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[pli_pkg::VAL_W-1:0];
  endfunction

  // Result sink: stall pattern of its own, and check each transfer in order.
  always @(posedge clk) begin : result_sink
    interp_t want;
    sink_cycle++;
    if (sink_cycle >= 96) begin
      sink_cycle = 0;
      sink_mode = $urandom_range(0, 3);
    end
    unique case (sink_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      2: out_ch.ready <= (sink_cycle % 4) != 3;
      default: begin
        if (hold_left == 0) begin
          hold_level = ~hold_level;
          hold_left = $urandom_range(1, 30);
        end else begin
          hold_left--;
        end
        out_ch.ready <= hold_level;
      end
    endcase
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_values.size() == 0) begin
        flag_mismatch("result with nothing pending", 'x, out_ch.result_y);
      end else begin
        want = pending_values.pop_front();
        results_seen++;
        if (out_ch.result_y !== want.y) begin
          flag_mismatch("result_y", want.y, out_ch.result_y);
        end
        if (out_ch.out_of_range !== want.oor) begin
          flag_mismatch("out_of_range", 32'(want.oor), 32'(out_ch.out_of_range));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles, %0d results outstanding", $time,
               IDLE_LIMIT, pending_values.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    pli_item_t it;
    interp_t typed_val;
    interp_t none;
    logic [pli_pkg::CFG_W-1:0] value;
    int n;
    int nq;
    int phase;
    int pick;
    none = '0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = pli_pkg::KIND_LOAD;
    in_ch.entry_index = '0;
    in_ch.point_x     = '0;
    in_ch.point_y     = '0;
    in_ch.query_x     = '0;
    out_ch.ready      = 1'b0;
    points_cfg        = pli_pkg::POINTS_RESET;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      knot_x[k] = '0;
      knot_y[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].do_cfg) write_points(DIRECTED[r].cfg_val);
      typed_val.y = DIRECTED[r].exp_y;
      typed_val.oor = DIRECTED[r].exp_oor;
      send_item(DIRECTED[r].item, DIRECTED[r].chk, typed_val);
    end

    // Random phases: new count, a fresh table, then queries with stray loads.
    phase = 0;
    while (items_done < ITEM_TARGET) begin
      if (phase < 8) begin
        value = PHASE_POINTS[phase];
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) value = pli_pkg::CFG_W'($urandom_range(0, 8));
        else if (pick < 85) value = pli_pkg::CFG_W'($urandom_range(9, 32));
        else value = pli_pkg::CFG_W'($urandom_range(33, 127));
      end
      write_points(value);
      n = points_active();
      load_table(n);
      nq = $urandom_range(15, 50);
      repeat (nq) begin
        it.entry_index = pli_pkg::IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        it.point_x     = $urandom;
        it.point_y     = $urandom;
        if ($urandom_range(0, 99) < 12) begin
          it.kind    = pli_pkg::KIND_LOAD;
          it.query_x = $urandom;
        end else begin
          it.kind    = pli_pkg::KIND_QUERY;
          it.query_x = pick_query(n);
        end
        send_item(it, 1'b0, none);
      end
      phase++;
    end

    // Drain, then give stray results a chance to show up.
    in_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d queries, %0d outside the table)",
             items_done, queries_done, oor_expected);
    $display("over %0d count settings; %0d results checked, %0d mismatches.",
             cfg_writes, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pli_pkg.sv
sv/pli_ifs.sv
sv/pli_bp_mem.sv
sv/pli_div.sv
sv/piecewise_linear_interpolator.sv
bench/tb.sv
